// ----- sv/cbed_pkg.sv -----
// Shared types and constants for the counter-based event debounce block.
package cbed_pkg;

  // Event table geometry.
  localparam int NUM_EVENTS = 256;
  localparam int EVENT_W    = 8;
  localparam int ADDR_W     = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;

  // Word widths.
  localparam int LEVEL_W  = 16;
  localparam int LIMIT_W  = 15;
  localparam int STATUS_W = 2;
  localparam int MODE_W   = 3;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;
  // Working width for sums of two level-sized operands and their compares.
  localparam int CALC_W   = LEVEL_W + 2;

  // Report and result status codes.
  localparam logic [STATUS_W-1:0] ST_PASSED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAILED    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PREPASSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PREFAILED = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PASSED_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAILED_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_UP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DOWN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_UP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_DOWN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FDC_THR    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_MODE  = 3'd7;

  // Jump mode bit positions.
  localparam int MODE_JUMP_DOWN  = 0;
  localparam int MODE_JUMP_UP    = 1;
  localparam int MODE_ONLY_LIMIT = 2;

  // Debounce parameter set shared by all events.
  typedef struct packed {
    logic signed [LEVEL_W-1:0] passed_threshold;
    logic [LIMIT_W-1:0]        failed_threshold;
    logic [LIMIT_W-1:0]        step_up;
    logic signed [LEVEL_W-1:0] step_down;
    logic signed [LEVEL_W-1:0] jump_up_value;
    logic signed [LEVEL_W-1:0] jump_down_value;
    logic signed [LEVEL_W-1:0] fdc_threshold;
    logic [MODE_W-1:0]         jump_mode;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [LEVEL_W-1:0] level;
    logic                      set_fdc;
    logic                      reset_fdc;
    logic                      allow_insert;
  } result_t;

endpackage

// ----- sv/counter_based_event_debounce_core.sv -----
// Top level of the counter-based event debounce block.
//
// The input channel (in_valid, in_stall) carries one monitor report word:
// event_id and report_status. The output channel (out_valid, out_stall)
// returns one result word per report: qualified_status, debounce_level and
// the set, reset and buffer-insert flags. Both channels use valid/stall;
// a word moves at a clock edge where valid is high and stall is low.
// Each report is a read-modify-write of one entry of the level memory:
// the entry is read at the accept edge, the new level is computed from the
// registered read data and written back together with the result word
// once the output register can take it. A new report is not accepted
// until the current one is written back; this one-report-in-flight
// interlock waits out the memory read latency.
// Reset clears the configuration to its defaults and marks every event
// level as zero through per-entry valid flags; no clearing pass is needed.
// On a receiver stall the result word holds in the output register; one more
// report may be accepted and computed, and it waits until that register frees.
// The user must write configuration only while idle; it is not enforced.
module counter_based_event_debounce_core import cbed_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [EVENT_W-1:0]        event_id,
  input  logic [STATUS_W-1:0]       report_status,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STATUS_W-1:0]       qualified_status,
  output logic signed [LEVEL_W-1:0] debounce_level,
  output logic                      set_fdc_reached,
  output logic                      reset_fdc_reached,
  output logic                      allow_buffer_insert
);

  cfg_t                      cfg;
  result_t                   calc_res;
  logic                      in_accept;
  logic                      busy;
  logic                      in_range;
  logic                      range_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [STATUS_W-1:0]       status_q;
  logic                      entry_vld_q;
  logic [NUM_EVENTS-1:0]     entry_vld;
  logic [LEVEL_W-1:0]        rd_data;
  logic signed [LEVEL_W-1:0] cur_level;
  logic                      wb;

  // Configuration registers.
  cbed_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Handshake: one report in flight at a time.
  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign in_range  = ({1'b0, event_id} < (EVENT_W+1)'(NUM_EVENTS));

  // Write back once the output register can take the result.
  assign wb = busy && (!out_valid || !out_stall);

  // Level memory, one entry per event.
  cbed_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (NUM_EVENTS)
  ) u_level_ram (
    .clk     (clk),
    .wr_en   (wb && range_q),
    .wr_addr (addr_q),
    .wr_data (calc_res.level),
    .rd_en   (in_accept),
    .rd_addr (event_id[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // An entry never written since reset reads as zero.
  assign cur_level = entry_vld_q ? $signed(rd_data) : '0;

  cbed_level_calc u_calc (
    .cfg           (cfg),
    .report_status (status_q),
    .level_in      (cur_level),
    .res           (calc_res)
  );

  // Control state and per-entry valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      entry_vld <= '0;
    end else begin
      if (in_accept) begin
        busy <= 1'b1;
      end else if (wb) begin
        busy <= 1'b0;
      end
      if (wb) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (wb && range_q) begin
        entry_vld[addr_q] <= 1'b1;
      end
    end
  end

  // Report word captured at acceptance.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      addr_q      <= event_id[ADDR_W-1:0];
      status_q    <= report_status;
      range_q     <= in_range;
      entry_vld_q <= entry_vld[event_id[ADDR_W-1:0]];
    end
  end

  // Output register; a report for an unknown event echoes its status.
  always_ff @(posedge clk) begin
    if (wb) begin
      if (range_q) begin
        qualified_status    <= calc_res.status;
        debounce_level      <= calc_res.level;
        set_fdc_reached     <= calc_res.set_fdc;
        reset_fdc_reached   <= calc_res.reset_fdc;
        allow_buffer_insert <= calc_res.allow_insert;
      end else begin
        qualified_status    <= status_q;
        debounce_level      <= '0;
        set_fdc_reached     <= 1'b0;
        reset_fdc_reached   <= 1'b0;
        allow_buffer_insert <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/cbed_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module cbed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/cbed_cfg_regs.sv -----
// Configuration register file for the debounce parameter set.
module cbed_cfg_regs import cbed_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  // Each register takes the low bits of the write data it needs.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.passed_threshold <= -16'sd128;
      cfg.failed_threshold <= 15'd127;
      cfg.step_up          <= 15'd1;
      cfg.step_down        <= -16'sd1;
      cfg.jump_up_value    <= 16'sd0;
      cfg.jump_down_value  <= 16'sd0;
      cfg.fdc_threshold    <= 16'sd127;
      cfg.jump_mode        <= 3'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PASSED_THR: cfg.passed_threshold <= $signed(cfg_data[LEVEL_W-1:0]);
        REG_FAILED_THR: cfg.failed_threshold <= cfg_data[LIMIT_W-1:0];
        REG_STEP_UP:    cfg.step_up          <= cfg_data[LIMIT_W-1:0];
        REG_STEP_DOWN:  cfg.step_down        <= $signed(cfg_data[LEVEL_W-1:0]);
        REG_JUMP_UP:    cfg.jump_up_value    <= $signed(cfg_data[LEVEL_W-1:0]);
        REG_JUMP_DOWN:  cfg.jump_down_value  <= $signed(cfg_data[LEVEL_W-1:0]);
        REG_FDC_THR:    cfg.fdc_threshold    <= $signed(cfg_data[LEVEL_W-1:0]);
        REG_JUMP_MODE:  cfg.jump_mode        <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/cbed_level_calc.sv -----
// Debounce level update: jump, step, limit, saturate and flag generation.
module cbed_level_calc import cbed_pkg::*; (
  input  cfg_t                      cfg,
  input  logic [STATUS_W-1:0]       report_status,
  input  logic signed [LEVEL_W-1:0] level_in,
  output result_t                   res
);

  logic signed [CALC_W-1:0] lvl;
  logic signed [CALC_W-1:0] passed;
  logic signed [CALC_W-1:0] failed;
  logic signed [CALC_W-1:0] up;
  logic signed [CALC_W-1:0] down;
  logic signed [CALC_W-1:0] jup;
  logic signed [CALC_W-1:0] jdown;
  logic signed [CALC_W-1:0] fdc;
  logic signed [CALC_W-1:0] max16;
  logic signed [CALC_W-1:0] min16;
  logic signed [CALC_W-1:0] dn_sum;
  logic signed [CALC_W-1:0] up_sum;
  logic signed [CALC_W-1:0] dn_lvl;
  logic signed [CALC_W-1:0] up_lvl;
  logic                     only_limit;
  logic                     jump_dn;
  logic                     jump_up;
  logic                     dn_hit;
  logic                     up_hit;

  // Bring every operand to one signed working width.
  assign lvl    = CALC_W'(level_in);
  assign passed = CALC_W'(cfg.passed_threshold);
  assign failed = $signed({{(CALC_W-LIMIT_W){1'b0}}, cfg.failed_threshold});
  assign up     = $signed({{(CALC_W-LIMIT_W){1'b0}}, cfg.step_up});
  assign down   = CALC_W'(cfg.step_down);
  assign jup    = CALC_W'(cfg.jump_up_value);
  assign jdown  = CALC_W'(cfg.jump_down_value);
  assign fdc    = CALC_W'(cfg.fdc_threshold);
  assign max16  = $signed({{(CALC_W-LEVEL_W+1){1'b0}}, {(LEVEL_W-1){1'b1}}});
  assign min16  = $signed({{(CALC_W-LEVEL_W+1){1'b1}}, {(LEVEL_W-1){1'b0}}});

  assign only_limit = cfg.jump_mode[MODE_ONLY_LIMIT];

  // Jump decisions, optionally only from the opposite limit.
  assign jump_dn = cfg.jump_mode[MODE_JUMP_DOWN] && (lvl > jdown) &&
                   ((lvl == failed) || !only_limit);
  assign jump_up = cfg.jump_mode[MODE_JUMP_UP] && (lvl < jup) &&
                   ((lvl == passed) || !only_limit);

  assign dn_sum = (jump_dn ? jdown : lvl) + down;
  assign up_sum = (jump_up ? jup : lvl) + up;

  // Clamp at the thresholds, then at the 16-bit range.
  assign dn_hit = (dn_sum <= passed);
  assign up_hit = (up_sum >= failed);

  always_comb begin
    dn_lvl = dn_hit ? passed : dn_sum;
    if (dn_lvl > max16) dn_lvl = max16;
    else if (dn_lvl < min16) dn_lvl = min16;
    up_lvl = up_hit ? failed : up_sum;
    if (up_lvl > max16) up_lvl = max16;
    else if (up_lvl < min16) up_lvl = min16;
  end

  // Select the outcome for the reported status.
  always_comb begin
    res.status       = report_status;
    res.level        = level_in;
    res.set_fdc      = 1'b0;
    res.reset_fdc    = 1'b0;
    res.allow_insert = 1'b0;
    case (report_status)
      ST_PREPASSED: begin
        if (lvl == passed) begin
          res.reset_fdc = 1'b1;
          res.status    = ST_PASSED;
        end else begin
          res.level = dn_lvl[LEVEL_W-1:0];
          if (dn_hit) res.status = ST_PASSED;
          res.reset_fdc = (dn_lvl < fdc);
        end
      end
      ST_PREFAILED: begin
        if (lvl == failed) begin
          res.set_fdc = 1'b1;
          res.status  = ST_FAILED;
        end else begin
          res.level = up_lvl[LEVEL_W-1:0];
          if (up_hit) res.status = ST_FAILED;
          res.set_fdc      = (up_lvl >= fdc);
          res.allow_insert = (up_lvl >= fdc) && !up_hit;
        end
      end
      ST_PASSED: begin
        res.reset_fdc = 1'b1;
        res.level     = cfg.passed_threshold;
      end
      default: begin
        res.set_fdc = 1'b1;
        res.level   = $signed({1'b0, cfg.failed_threshold});
      end
    endcase
  end

endmodule
